FILE: hdl/sbe_pkg.sv
// Shared opcodes, program-counter actions and error codes for the stack bytecode executor.
package sbe_pkg;

    // Instruction opcodes carried in the mode field.
    typedef enum logic [3:0] {
        OP_FETCH = 4'd0,
        OP_STORE = 4'd1,
        OP_PUSH  = 4'd2,
        OP_POP   = 4'd3,
        OP_ADD   = 4'd4,
        OP_SUB   = 4'd5,
        OP_LESS  = 4'd6,
        OP_JZ    = 4'd7,
        OP_JNZ   = 4'd8,
        OP_JMP   = 4'd9,
        OP_HALT  = 4'd10
    } t_op;

    // Program-counter action reported with each result.
    typedef enum logic [1:0] {
        PC_ADVANCE = 2'd0,
        PC_JUMP    = 2'd1,
        PC_HALTED  = 2'd2
    } t_pc_act;

    // Error codes reported with each result.
    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_OVER  = 2'd2,
        ERR_INDEX = 2'd3
    } t_err;

endpackage

FILE: hdl/stack_bytecode_executor.sv
// Stack bytecode executor: one instruction per beat on a RAM-backed operand stack.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_mode, i_operand
//  out     | output    | o_out_valid / i_out_stall | o_pc_action, o_jump_target,
//          |           |                           | o_top_value, o_stack_count,
//          |           |                           | o_error_code, o_store_*
//
// A new beat is accepted every cycle the output register is empty or being
// drained. The rate is set by the stack RAM: the top two entries live in
// registers and the third is read ahead from the RAM into a register, so no step
// waits for a read. The result appears in the output register in the cycle after
// the input beat is accepted. Reset (synchronous, active low) empties the stack,
// clears the global variables and the halt flag; the stack RAM needs no
// clearing. While the output is stalled with a result held, the input is stalled.
module stack_bytecode_executor #(
    parameter int STACK_DEPTH = 64,
    parameter int VAR_COUNT   = 26,
    localparam int SpW  = $clog2(STACK_DEPTH + 1),
    localparam int IdxW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [3:0]      i_mode,
    input  logic [31:0]     i_operand,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [1:0]      o_pc_action,
    output logic [31:0]     o_jump_target,
    output logic [31:0]     o_top_value,
    output logic [SpW-1:0]  o_stack_count,
    output logic [1:0]      o_error_code,
    output logic            o_store_valid,
    output logic [IdxW-1:0] o_store_index,
    output logic [31:0]     o_store_value
);
    import sbe_pkg::*;

    localparam int AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // Stack RAM holds every pushed entry; registers hold the top two entries.
    logic [31:0]      r_stack_mem [STACK_DEPTH];
    logic [31:0]      r_third;
    logic [31:0]      r_top, n_top;
    logic [31:0]      r_nxt, n_nxt;
    logic [SpW-1:0]   r_sp, n_sp;
    logic             r_halted, n_halted;
    logic [31:0]      r_glob [VAR_COUNT];

    logic             r_out_valid;
    logic             acc;
    logic             full;
    logic             idx_ok;
    logic [IdxW-1:0]  idx;
    logic [SpW-1:0]   sp_m2;
    logic [SpW-1:0]   rd_sp;
    logic [SpW-1:0]   rd_sp_m3;
    logic [AddrW-1:0] rd_addr;
    logic             we;
    logic [AddrW-1:0] wa;
    logic [31:0]      wd;

    t_pc_act          act;
    t_err             err;
    logic [31:0]      tgt;
    logic             st_v;
    logic [IdxW-1:0]  st_i;
    logic [31:0]      st_val;
    logic [31:0]      sum;
    logic [31:0]      diff;
    logic             lt;

    // Input is taken whenever the output register is free or draining this cycle.
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign acc         = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    assign full   = (r_sp == SpW'(STACK_DEPTH));
    assign idx_ok = ($unsigned(i_operand) < 32'(VAR_COUNT));
    assign idx    = i_operand[IdxW-1:0];
    assign sp_m2  = r_sp - SpW'(2);
    assign sum    = r_nxt + r_top;
    assign diff   = r_nxt - r_top;
    assign lt     = ($signed(r_nxt) < $signed(r_top));

    // Execute one instruction against the top-of-stack registers.
    always_comb begin
        n_sp     = r_sp;
        n_top    = r_top;
        n_nxt    = r_nxt;
        n_halted = r_halted;
        act      = PC_ADVANCE;
        err      = ERR_NONE;
        tgt      = '0;
        st_v     = 1'b0;
        st_i     = '0;
        st_val   = '0;
        we       = 1'b0;
        wa       = r_sp[AddrW-1:0];
        wd       = '0;
        if (r_halted) begin
            act = PC_HALTED;
        end else begin
            unique case (t_op'(i_mode))
                OP_FETCH: begin
                    if (!idx_ok) begin
                        err = ERR_INDEX;
                    end else if (full) begin
                        err = ERR_OVER;
                    end else begin
                        n_sp  = r_sp + SpW'(1);
                        n_top = r_glob[idx];
                        n_nxt = r_top;
                        we    = 1'b1;
                        wd    = r_glob[idx];
                    end
                end
                OP_STORE: begin
                    if (r_sp == '0) begin
                        err = ERR_UNDER;
                    end else if (!idx_ok) begin
                        err = ERR_INDEX;
                    end else begin
                        st_v   = 1'b1;
                        st_i   = idx;
                        st_val = r_top;
                    end
                end
                OP_PUSH: begin
                    if (full) begin
                        err = ERR_OVER;
                    end else begin
                        n_sp  = r_sp + SpW'(1);
                        n_top = i_operand;
                        n_nxt = r_top;
                        we    = 1'b1;
                        wd    = i_operand;
                    end
                end
                OP_POP: begin
                    if (r_sp == '0) begin
                        err = ERR_UNDER;
                    end else begin
                        n_sp  = r_sp - SpW'(1);
                        n_top = r_nxt;
                        n_nxt = r_third;
                    end
                end
                OP_ADD, OP_SUB, OP_LESS: begin
                    if (r_sp < SpW'(2)) begin
                        err = ERR_UNDER;
                    end else begin
                        n_sp = r_sp - SpW'(1);
                        if (t_op'(i_mode) == OP_ADD) begin
                            n_top = sum;
                        end else if (t_op'(i_mode) == OP_SUB) begin
                            n_top = diff;
                        end else begin
                            n_top = {31'd0, lt};
                        end
                        n_nxt = r_third;
                        we    = 1'b1;
                        wa    = sp_m2[AddrW-1:0];
                        wd    = n_top;
                    end
                end
                OP_JZ, OP_JNZ: begin
                    if (r_sp == '0) begin
                        err = ERR_UNDER;
                    end else begin
                        if ((t_op'(i_mode) == OP_JZ) == (r_top == '0)) begin
                            act = PC_JUMP;
                            tgt = i_operand;
                        end
                        n_sp  = r_sp - SpW'(1);
                        n_top = r_nxt;
                        n_nxt = r_third;
                    end
                end
                OP_JMP: begin
                    act = PC_JUMP;
                    tgt = i_operand;
                end
                OP_HALT: begin
                    n_halted = 1'b1;
                    act      = PC_HALTED;
                end
                default: begin
                end
            endcase
        end
    end

    // Read address tracks the entry that will sit third from the top next cycle.
    assign rd_sp    = acc ? n_sp : r_sp;
    assign rd_sp_m3 = rd_sp - SpW'(3);
    assign rd_addr  = rd_sp_m3[AddrW-1:0];

    // Stack RAM: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (acc && we) begin
            r_stack_mem[wa] <= wd;
        end
        r_third <= r_stack_mem[rd_addr];
    end

    // Control state, top-of-stack registers and global variables.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp     <= '0;
            r_halted <= 1'b0;
            for (int i = 0; i < VAR_COUNT; i++) begin
                r_glob[i] <= '0;
            end
        end else if (acc) begin
            r_sp     <= n_sp;
            r_halted <= n_halted;
            if (st_v) begin
                r_glob[st_i] <= st_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_top <= n_top;
            r_nxt <= n_nxt;
        end
    end

    // Output register holds one result beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            o_pc_action   <= act;
            o_jump_target <= tgt;
            o_top_value   <= (n_sp == '0) ? 32'd0 : n_top;
            o_stack_count <= n_sp;
            o_error_code  <= err;
            o_store_valid <= st_v;
            o_store_index <= st_i;
            o_store_value <= st_val;
        end
    end

endmodule

FILE: hdl/sbe_checker.sv
// Port-level checks for the stack bytecode executor, bound to its top level.
module sbe_checker #(
    parameter int STACK_DEPTH = 64,
    parameter int VAR_COUNT   = 26,
    localparam int SpW  = $clog2(STACK_DEPTH + 1),
    localparam int IdxW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1
) (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input logic [1:0]      o_pc_action,
    input logic [31:0]     o_top_value,
    input logic [SpW-1:0]  o_stack_count,
    input logic [1:0]      o_error_code,
    input logic            o_store_valid,
    input logic [IdxW-1:0] o_store_index,
    input logic [31:0]     o_store_value
);
    import sbe_pkg::*;

    logic           out_acc;
    logic           r_seen_halt;
    logic           r_have_cnt;
    logic [SpW-1:0] r_last_cnt;

    assign out_acc = o_out_valid && !i_out_stall;

    // Track the last delivered beat's depth and whether a halt was delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_halt <= 1'b0;
            r_have_cnt  <= 1'b0;
        end else if (out_acc) begin
            r_have_cnt <= 1'b1;
            if (o_pc_action == PC_HALTED) begin
                r_seen_halt <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_last_cnt <= o_stack_count;
        end
    end

    // Once halted, every later result reports halted.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_seen_halt |-> o_pc_action == PC_HALTED)
        else $error("result after halt is not halted");

    // The depth moves by at most one entry per instruction.
    a_depth_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && r_have_cnt |->
            (o_stack_count == r_last_cnt) ||
            (o_stack_count == r_last_cnt + SpW'(1)) ||
            (o_stack_count + SpW'(1) == r_last_cnt))
        else $error("stack depth jumped by more than one");

    // A faulting step neither jumps nor stores.
    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error_code != ERR_NONE |->
            o_pc_action == PC_ADVANCE && !o_store_valid)
        else $error("faulting step had side effects");

    // Depth stays in range and an empty stack shows a zero top.
    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_stack_count <= SpW'(STACK_DEPTH) &&
            (o_stack_count != '0 || o_top_value == '0))
        else $error("stack depth or empty top value out of range");

    // A store names a valid variable and carries the top of stack.
    a_store_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_store_valid |->
            32'(o_store_index) < 32'(VAR_COUNT) && o_store_value == o_top_value &&
            o_stack_count != '0)
        else $error("store beat is inconsistent");

endmodule

bind stack_bytecode_executor sbe_checker #(
    .STACK_DEPTH(STACK_DEPTH),
    .VAR_COUNT  (VAR_COUNT)
) u_sbe_checker (.*);

FILE: sim/stack_bytecode_executor_tb.sv
// Self-checking testbench for the stack bytecode executor: directed table, random programs.
module stack_bytecode_executor_tb;
    import sbe_pkg::*;

    localparam int STACK_SLOTS = 64;
    localparam int VAR_SLOTS   = 26;
    localparam int RUN_LIMIT   = 300000;
    localparam int PHASE_BEATS = 200;
    localparam int DRAIN_WAIT  = 8;

    // Opcode outside the defined set; the block must treat it as a no-op.
    localparam logic [3:0] OP_UNDEFINED = 4'hF;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        t_pc_act     pc_action;
        logic [31:0] jump_target;
        logic [31:0] top_value;
        logic [6:0]  stack_count;
        t_err        error_code;
        logic        store_valid;
        logic [4:0]  store_index;
        logic [31:0] store_value;
    } exec_result_t;

    typedef struct packed {
        logic [3:0]   mode;
        logic [31:0]  operand;
        logic         typed;
        exec_result_t want;
    } step_row_t;

    // Directed program; rows with typed set carry their answer, the rest use the predictor.
    // The halt rows come last and run only after the random part, since halt is sticky.
    localparam int N_ROWS   = 25;
    localparam int HALT_ROW = 22;
    localparam step_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{OP_POP,   32'd0, 1'b1, '{PC_ADVANCE, 32'd0, 32'd0, 7'd0, ERR_UNDER, 1'b0, 5'd0, 32'd0}},
        '{OP_STORE, 32'hFFFF_FFFF, 1'b1,
          '{PC_ADVANCE, 32'd0, 32'd0, 7'd0, ERR_UNDER, 1'b0, 5'd0, 32'd0}},
        '{OP_ADD,   32'd0, 1'b1, '{PC_ADVANCE, 32'd0, 32'd0, 7'd0, ERR_UNDER, 1'b0, 5'd0, 32'd0}},
        '{OP_JZ,    32'd5, 1'b1, '{PC_ADVANCE, 32'd0, 32'd0, 7'd0, ERR_UNDER, 1'b0, 5'd0, 32'd0}},
        '{OP_FETCH, 32'd25, 1'b1, '{PC_ADVANCE, 32'd0, 32'd0, 7'd1, ERR_NONE, 1'b0, 5'd0, 32'd0}},
        '{OP_FETCH, 32'd26, 1'b1, '{PC_ADVANCE, 32'd0, 32'd0, 7'd1, ERR_INDEX, 1'b0, 5'd0, 32'd0}},
        '{OP_FETCH, 32'hFFFF_FFFF, 1'b1,
          '{PC_ADVANCE, 32'd0, 32'd0, 7'd1, ERR_INDEX, 1'b0, 5'd0, 32'd0}},
        '{OP_PUSH,  INT_MAX, 1'b1, '{PC_ADVANCE, 32'd0, INT_MAX, 7'd2, ERR_NONE, 1'b0, 5'd0, 32'd0}},
        '{OP_PUSH,  32'd1, 1'b1, '{PC_ADVANCE, 32'd0, 32'd1, 7'd3, ERR_NONE, 1'b0, 5'd0, 32'd0}},
        '{OP_ADD,   32'd0, 1'b1, '{PC_ADVANCE, 32'd0, INT_MIN, 7'd2, ERR_NONE, 1'b0, 5'd0, 32'd0}},
        '{OP_STORE, 32'd25, 1'b1,
          '{PC_ADVANCE, 32'd0, INT_MIN, 7'd2, ERR_NONE, 1'b1, 5'd25, INT_MIN}},
        '{OP_STORE, 32'd26, 1'b1,
          '{PC_ADVANCE, 32'd0, INT_MIN, 7'd2, ERR_INDEX, 1'b0, 5'd0, 32'd0}},
        '{OP_FETCH, 32'd25, 1'b0, '0},
        '{OP_PUSH,  32'd1, 1'b0, '0},
        '{OP_LESS,  32'd0, 1'b0, '0},
        '{OP_SUB,   32'd0, 1'b0, '0},
        '{OP_JNZ,   INT_MAX, 1'b1, '{PC_JUMP, INT_MAX, 32'd0, 7'd1, ERR_NONE, 1'b0, 5'd0, 32'd0}},
        '{OP_JZ,    INT_MIN, 1'b1, '{PC_JUMP, INT_MIN, 32'd0, 7'd0, ERR_NONE, 1'b0, 5'd0, 32'd0}},
        '{OP_PUSH,  32'd5, 1'b0, '0},
        '{OP_JZ,    32'd3, 1'b1, '{PC_ADVANCE, 32'd0, 32'd0, 7'd0, ERR_NONE, 1'b0, 5'd0, 32'd0}},
        '{OP_JMP,   32'hFFFF_FFFF, 1'b1,
          '{PC_JUMP, 32'hFFFF_FFFF, 32'd0, 7'd0, ERR_NONE, 1'b0, 5'd0, 32'd0}},
        '{OP_UNDEFINED, 32'd123, 1'b1,
          '{PC_ADVANCE, 32'd0, 32'd0, 7'd0, ERR_NONE, 1'b0, 5'd0, 32'd0}},
        '{OP_HALT,  32'h1234_5678, 1'b0, '0},
        '{OP_PUSH,  32'd9, 1'b0, '0},
        '{OP_STORE, 32'd0, 1'b0, '0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [3:0]  i_mode = 4'd0;
    logic [31:0] i_operand = 32'd0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_pc_action;
    logic [31:0] o_jump_target;
    logic [31:0] o_top_value;
    logic [6:0]  o_stack_count;
    logic [1:0]  o_error_code;
    logic        o_store_valid;
    logic [4:0]  o_store_index;
    logic [31:0] o_store_value;

    // Predicted machine state.
    logic [31:0] op_stack [STACK_SLOTS];
    logic [31:0] globals [VAR_SLOTS];
    int          depth = 0;
    logic        halted = 1'b0;
    bit          climbing = 1'b1;

    exec_result_t results_due [$];
    int           mismatches = 0;
    int           cycles = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;

    stack_bytecode_executor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_operand     (i_operand),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pc_action   (o_pc_action),
        .o_jump_target (o_jump_target),
        .o_top_value   (o_top_value),
        .o_stack_count (o_stack_count),
        .o_error_code  (o_error_code),
        .o_store_valid (o_store_valid),
        .o_store_index (o_store_index),
        .o_store_value (o_store_value)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Executes one instruction on the predicted state and returns its result.
    function automatic exec_result_t predict_exec(input logic [3:0] mode, input logic [31:0] arg);
        exec_result_t res;
        logic [31:0]  lhs;
        logic [31:0]  rhs;
        res = '0;
        res.pc_action = PC_ADVANCE;
        res.error_code = ERR_NONE;
        if (halted) begin
            res.pc_action = PC_HALTED;
        end else begin
            case (mode)
                OP_FETCH: begin
                    if (arg >= VAR_SLOTS) begin
                        res.error_code = ERR_INDEX;
                    end else if (depth == STACK_SLOTS) begin
                        res.error_code = ERR_OVER;
                    end else begin
                        op_stack[depth] = globals[arg[4:0]];
                        depth++;
                    end
                end
                OP_STORE: begin
                    if (depth == 0) begin
                        res.error_code = ERR_UNDER;
                    end else if (arg >= VAR_SLOTS) begin
                        res.error_code = ERR_INDEX;
                    end else begin
                        globals[arg[4:0]] = op_stack[depth-1];
                        res.store_valid = 1'b1;
                        res.store_index = arg[4:0];
                        res.store_value = op_stack[depth-1];
                    end
                end
                OP_PUSH: begin
                    if (depth == STACK_SLOTS) begin
                        res.error_code = ERR_OVER;
                    end else begin
                        op_stack[depth] = arg;
                        depth++;
                    end
                end
                OP_POP: begin
                    if (depth == 0) res.error_code = ERR_UNDER;
                    else depth--;
                end
                OP_ADD, OP_SUB, OP_LESS: begin
                    if (depth < 2) begin
                        res.error_code = ERR_UNDER;
                    end else begin
                        rhs = op_stack[depth-1];
                        lhs = op_stack[depth-2];
                        depth--;
                        if (mode == OP_ADD) op_stack[depth-1] = lhs + rhs;
                        else if (mode == OP_SUB) op_stack[depth-1] = lhs - rhs;
                        else op_stack[depth-1] = ($signed(lhs) < $signed(rhs)) ? 32'd1 : 32'd0;
                    end
                end
                OP_JZ, OP_JNZ: begin
                    if (depth == 0) begin
                        res.error_code = ERR_UNDER;
                    end else begin
                        // Test the top first, then drop it.
                        if ((mode == OP_JZ) == (op_stack[depth-1] == 32'd0)) begin
                            res.pc_action = PC_JUMP;
                            res.jump_target = arg;
                        end
                        depth--;
                    end
                end
                OP_JMP: begin
                    res.pc_action = PC_JUMP;
                    res.jump_target = arg;
                end
                OP_HALT: begin
                    halted = 1'b1;
                    res.pc_action = PC_HALTED;
                end
                default: ;
            endcase
        end
        res.top_value = (depth == 0) ? 32'd0 : op_stack[depth-1];
        res.stack_count = 7'(depth);
        return res;
    endfunction

    // Data value biased toward the signed extremes and small numbers.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return INT_MIN;
            1: return INT_MAX;
            2: return 32'hFFFF_FFFF;
            3: return 32'($urandom_range(3));
            default: return $urandom;
        endcase
    endfunction

    // Variable index, mostly in range.
    function automatic logic [31:0] pick_index();
        case ($urandom_range(19))
            0: return 32'($urandom_range(31, VAR_SLOTS));
            1: return $urandom | INT_MIN;
            2: return $urandom;
            default: return 32'($urandom_range(VAR_SLOTS - 1));
        endcase
    endfunction

    // Random instruction that fills the stack, then works it back down with real operations.
    task automatic pick_instr(output logic [3:0] mode, output logic [31:0] arg);
        int roll;
        roll = $urandom_range(99);
        if (climbing && depth == STACK_SLOTS && $urandom_range(3) == 0) climbing = 1'b0;
        else if (!climbing && depth == 0 && $urandom_range(1) == 0) climbing = 1'b1;
        else if ($urandom_range(99) < 2) climbing = !climbing;
        if (roll < 5) begin
            // Noise: any opcode but halt, including the undefined ones.
            mode = 4'($urandom_range(15));
            if (mode == OP_HALT) mode = OP_UNDEFINED;
            arg = $urandom;
        end else if (roll < 9) begin
            mode = OP_JMP;
            arg = pick_value();
        end else if (climbing) begin
            mode = (roll < 65) ? OP_PUSH : OP_FETCH;
            arg = (mode == OP_PUSH) ? pick_value() : pick_index();
        end else begin
            case ($urandom_range(19))
                0, 1, 2, 3, 4: mode = OP_POP;
                5, 6, 7:       mode = OP_ADD;
                8, 9, 10:      mode = OP_SUB;
                11, 12:        mode = OP_LESS;
                13, 14:        mode = OP_JZ;
                15, 16:        mode = OP_JNZ;
                default:       mode = OP_STORE;
            endcase
            arg = (mode == OP_STORE) ? pick_index() : pick_value();
        end
    endtask

    // Offers one beat, waits for it to be taken and queues its expected result.
    task automatic send_instr(input logic [3:0] mode, input logic [31:0] arg,
                              input logic typed, input exec_result_t typed_res);
        exec_result_t predicted;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_operand <= arg;
        do @(posedge i_clk); while (o_in_stall);
        predicted = predict_exec(mode, arg);
        results_due.push_back(typed ? typed_res : predicted);
    endtask

    // Holds the input idle until every expected result has come out.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_result(input exec_result_t want);
        if (o_pc_action !== want.pc_action) begin
            $error("pc_action: expected %0d, got %0d", want.pc_action, o_pc_action);
            mismatches++;
        end
        if (o_jump_target !== want.jump_target) begin
            $error("jump_target: expected %h, got %h", want.jump_target, o_jump_target);
            mismatches++;
        end
        if (o_top_value !== want.top_value) begin
            $error("top_value: expected %h, got %h", want.top_value, o_top_value);
            mismatches++;
        end
        if (o_stack_count !== want.stack_count) begin
            $error("stack_count: expected %0d, got %0d", want.stack_count, o_stack_count);
            mismatches++;
        end
        if (o_error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, o_error_code);
            mismatches++;
        end
        if (o_store_valid !== want.store_valid) begin
            $error("store_valid: expected %0d, got %0d", want.store_valid, o_store_valid);
            mismatches++;
        end
        if (o_store_index !== want.store_index) begin
            $error("store_index: expected %0d, got %0d", want.store_index, o_store_index);
            mismatches++;
        end
        if (o_store_value !== want.store_value) begin
            $error("store_value: expected %h, got %h", want.store_value, o_store_value);
            mismatches++;
        end
    endtask

    // Result side: check each accepted beat and drive a random stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                $error("result beat with no expectation pending");
                mismatches++;
            end else begin
                check_result(results_due.pop_front());
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [3:0]  mode;
        logic [31:0] arg;
        foreach (globals[k]) globals[k] = 32'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed program up to the halt rows.
        idle_pct = 11;
        stall_pct = 11;
        for (int r = 0; r < HALT_ROW; r++) begin
            send_instr(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].operand,
                       DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        end
        drain();

        // Random programs under four flow-control mixes, draining between them.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 88; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            for (int n = 0; n < PHASE_BEATS; n++) begin
                pick_instr(mode, arg);
                send_instr(mode, arg, 1'b0, '0);
            end
            drain();
        end

        // Halt and the steps after it, which must all report halted.
        for (int r = HALT_ROW; r < N_ROWS; r++) begin
            send_instr(DIRECTED_ROWS[r].mode, DIRECTED_ROWS[r].operand,
                       DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
        end
        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/sbe_pkg.sv
hdl/stack_bytecode_executor.sv
hdl/sbe_checker.sv
sim/stack_bytecode_executor_tb.sv
